### rtl/core/gf_pkg.sv
// ----------------------------------------------------------------------------
// gf_pkg
// shared widths, command and status types for the gravity force engine
// ----------------------------------------------------------------------------
package gf_pkg;

	localparam int MASS_W  = 32;
	localparam int POS_W   = 32;
	localparam int G_W     = 32;
	localparam int FORCE_W = 64;
	localparam int INDEX_W = 6;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	// register map, word index taken from paddr[2]
	localparam logic [0:0] REG_BIG_G = 1'b0;
	localparam logic [G_W-1:0] BIG_G_RESET = 32'h0100_0000;

	// iteration bounds of the shared units: last step index, or step count for BASE_STEPS
	localparam logic [5:0] SQRT_LAST  = 6'd49;
	localparam logic [5:0] BASE_STEPS = 6'd32;
	localparam logic [5:0] DEN_LAST   = 6'd49;
	localparam logic [5:0] NUM_LAST   = 6'd32;
	localparam logic [5:0] DIV_LAST   = 6'd62;

	typedef struct packed {
		logic body_wr;
		logic diff;
		logic sqr;
		logic sum;
		logic sqrt_step;
		logic base_step;
		logic den_init;
		logic den_step;
		logic num_init;
		logic num_step;
		logic div_init;
		logic div_step;
		logic acc_wr;
		logic acc_k;
		logic acc_clear;
		logic emit_ld;
		logic emit_last;
	} cmd_t;

	typedef struct packed {
		logic r2_zero;
		logic out_busy;
	} sts_t;

	typedef struct packed {
		logic                         err;
		logic [2:0][FORCE_W-1:0]      f;
	} acc_row_t;

endpackage

### rtl/core/gf_if.sv
// ----------------------------------------------------------------------------
// gf_if
// stream channels of the gravity force engine: body beats in, force beats out
// ----------------------------------------------------------------------------
interface gf_in_if;
	logic               valid;
	logic               ready;
	logic        [31:0] mass;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic               is_fixed;
	logic               last_body;

	modport source (output valid, mass, pos_x, pos_y, pos_z, is_fixed, last_body,
		input ready);
	modport sink (input valid, mass, pos_x, pos_y, pos_z, is_fixed, last_body,
		output ready);
endinterface

interface gf_out_if;
	logic               valid;
	logic               ready;
	logic        [5:0]  body_index;
	logic signed [63:0] force_x;
	logic signed [63:0] force_y;
	logic signed [63:0] force_z;
	logic               apply_force;
	logic               pair_error;
	logic               last_result;

	modport source (output valid, body_index, force_x, force_y, force_z, apply_force,
		pair_error, last_result, input ready);
	modport sink (input valid, body_index, force_x, force_y, force_z, apply_force,
		pair_error, last_result, output ready);
endinterface

### rtl/core/gf_isqrt.sv
// ----------------------------------------------------------------------------
// gf_isqrt
// digit-by-digit integer square root of r2 * 2^32, one root bit per step
// ----------------------------------------------------------------------------
module gf_isqrt (
	input  logic        clk,
	input  logic        init,
	input  logic        step,
	input  logic [65:0] r2,
	output logic [49:0] root
);
	logic [99:0] rad_q;
	logic [53:0] rem_q;
	logic [49:0] root_q;
	logic [53:0] rem_sh;
	logic [53:0] trial;
	logic        ge;

	assign rem_sh = {rem_q[51:0], rad_q[99:98]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign root   = root_q;

	always_ff @(posedge clk) begin
		if (init) begin
			rad_q  <= {2'b00, r2, 32'd0};
			rem_q  <= '0;
			root_q <= '0;
		end else if (step) begin
			rad_q  <= {rad_q[97:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[48:0], ge};
		end
	end
endmodule

### rtl/core/gf_lane.sv
// ----------------------------------------------------------------------------
// gf_lane
// one force axis: shift-add numerator product, then restoring division
// ----------------------------------------------------------------------------
module gf_lane (
	input  logic         clk,
	input  logic         num_init,
	input  logic         num_step,
	input  logic         div_init,
	input  logic         div_step,
	input  logic [95:0]  base,
	input  logic [32:0]  ad,
	input  logic [115:0] den,
	output logic [62:0]  q,
	output logic         ovf
);
	logic [128:0] prod_q;
	logic [32:0]  mplr_q;
	logic [116:0] rem_q;
	logic [62:0]  low_q;
	logic [62:0]  q_q;
	logic         ovf_q;
	logic [116:0] rem_sh;
	logic         ge;

	assign rem_sh = {rem_q[115:0], low_q[62]};
	assign ge     = rem_sh >= {1'b0, den};
	assign q      = q_q;
	assign ovf    = ovf_q;

	always_ff @(posedge clk) begin
		if (num_init) begin
			prod_q <= '0;
			mplr_q <= ad;
		end else if (num_step) begin
			prod_q <= {prod_q[127:0], 1'b0} + (mplr_q[32] ? {33'd0, base} : 129'd0);
			mplr_q <= {mplr_q[31:0], 1'b0};
		end
		if (div_init) begin
			// numerator is prod * 2^24; quotient of 2^63 or more saturates
			ovf_q <= {26'd0, prod_q} >= {den, 39'd0};
			rem_q <= {27'd0, prod_q[128:39]};
			low_q <= {prod_q[38:0], 24'd0};
			q_q   <= '0;
		end else if (div_step) begin
			rem_q <= ge ? rem_sh - {1'b0, den} : rem_sh;
			low_q <= {low_q[61:0], 1'b0};
			q_q   <= {q_q[61:0], ge};
		end
	end
endmodule

### rtl/core/gf_dp.sv
// ----------------------------------------------------------------------------
// gf_dp
// datapath: body store, pair arithmetic, force accumulators, result register
// ----------------------------------------------------------------------------
module gf_dp #(
	parameter int MAX_BODIES = 64,
	parameter int AW = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gf_pkg::cmd_t       cmd,
	output gf_pkg::sts_t       sts,
	input  logic [AW-1:0]      idx_ld,
	input  logic [AW-1:0]      idx_a,
	input  logic [AW-1:0]      idx_b,
	input  logic [AW-1:0]      idx_acc,
	input  logic [31:0]        big_g,
	input  logic [31:0]        in_mass,
	input  logic signed [31:0] in_pos_x,
	input  logic signed [31:0] in_pos_y,
	input  logic signed [31:0] in_pos_z,
	input  logic               in_fixed,
	gf_out_if.source           res
);
	import gf_pkg::*;

	localparam logic [FORCE_W-1:0] F_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
	localparam logic [FORCE_W-1:0] F_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

	// body store
	logic [MASS_W-1:0]  mass_mem [MAX_BODIES];
	logic [3*POS_W-1:0] pos_mem  [MAX_BODIES];
	logic               fix_mem  [MAX_BODIES];
	logic [MASS_W-1:0]  ra_mass_q, rb_mass_q;
	logic [3*POS_W-1:0] ra_pos_q, rb_pos_q;
	logic               ra_fix_q;

	// pair arithmetic
	logic [32:0]  ad_q  [3];
	logic         neg_q [3];
	logic [65:0]  sq_q  [3];
	logic [63:0]  base64_q;
	logic [31:0]  mk_q;
	logic [95:0]  base96_q;
	logic [65:0]  r2_d, r2_q;
	logic         zero_q;
	logic [49:0]  root;
	logic [49:0]  rr_q;
	logic [115:0] den_q;
	logic [62:0]  lane_q   [3];
	logic         lane_ovf [3];
	logic [32:0]  dsum     [3];

	// accumulators
	acc_row_t     acc_mem [MAX_BODIES];
	logic [MAX_BODIES-1:0] valid_q;
	acc_row_t     row_q, row_eff, row_new;
	logic         rowv_q;
	logic [62:0]  qmag   [3];
	logic [63:0]  addend [3];
	logic [64:0]  sum65  [3];
	logic [2:0]   sat;
	logic         err_pair;

	logic         out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.body_wr) begin
			mass_mem[idx_ld] <= in_mass;
			pos_mem[idx_ld]  <= {in_pos_z, in_pos_y, in_pos_x};
			fix_mem[idx_ld]  <= in_fixed;
		end
		ra_mass_q <= mass_mem[idx_a];
		ra_pos_q  <= pos_mem[idx_a];
		ra_fix_q  <= fix_mem[idx_a];
		rb_mass_q <= mass_mem[idx_b];
		rb_pos_q  <= pos_mem[idx_b];
	end

	// d = pos_k - pos_j per axis, 33 bits signed
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			dsum[c] = {rb_pos_q[c*POS_W+POS_W-1], rb_pos_q[c*POS_W +: POS_W]}
				- {ra_pos_q[c*POS_W+POS_W-1], ra_pos_q[c*POS_W +: POS_W]};
		end
	end

	assign r2_d = sq_q[0] + sq_q[1] + sq_q[2];

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			for (int c = 0; c < 3; c++) begin
				neg_q[c] <= dsum[c][32];
				ad_q[c]  <= dsum[c][32] ? 33'd0 - dsum[c] : dsum[c];
			end
			base64_q <= 64'(big_g) * 64'(ra_mass_q);
			mk_q     <= rb_mass_q;
		end
		if (cmd.sqr) begin
			for (int c = 0; c < 3; c++) begin
				sq_q[c] <= 66'(ad_q[c]) * 66'(ad_q[c]);
			end
		end
		if (cmd.sum) begin
			r2_q     <= r2_d;
			zero_q   <= sts.r2_zero;
			base96_q <= '0;
		end else if (cmd.base_step) begin
			base96_q <= {base96_q[94:0], 1'b0} + (mk_q[31] ? {32'd0, base64_q} : 96'd0);
			mk_q     <= {mk_q[30:0], 1'b0};
		end
		if (cmd.den_init) begin
			den_q <= '0;
			rr_q  <= root;
		end else if (cmd.den_step) begin
			den_q <= {den_q[114:0], 1'b0} + (rr_q[49] ? {50'd0, r2_q} : 116'd0);
			rr_q  <= {rr_q[48:0], 1'b0};
		end
	end

	gf_isqrt u_isqrt (
		.clk  (clk),
		.init (cmd.sum),
		.step (cmd.sqrt_step),
		.r2   (r2_d),
		.root (root)
	);

	for (genvar c = 0; c < 3; c++) begin : g_lane
		gf_lane u_lane (
			.clk      (clk),
			.num_init (cmd.num_init),
			.num_step (cmd.num_step),
			.div_init (cmd.div_init),
			.div_step (cmd.div_step),
			.base     (base96_q),
			.ad       (ad_q[c]),
			.den      (den_q),
			.q        (lane_q[c]),
			.ovf      (lane_ovf[c])
		);
	end

	// accumulator row update, saturating per axis
	always_ff @(posedge clk) begin
		row_q  <= acc_mem[idx_acc];
		rowv_q <= valid_q[idx_acc];
		if (cmd.acc_wr) begin
			acc_mem[idx_acc] <= row_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.acc_clear) begin
			valid_q <= '0;
		end else if (cmd.acc_wr) begin
			valid_q[idx_acc] <= 1'b1;
		end
	end

	assign row_eff  = rowv_q ? row_q : '0;
	assign err_pair = zero_q | lane_ovf[0] | lane_ovf[1] | lane_ovf[2];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (zero_q) begin
				qmag[c] = '0;
			end else if (lane_ovf[c]) begin
				qmag[c] = '1;
			end else begin
				qmag[c] = lane_q[c];
			end
			addend[c] = (neg_q[c] ^ cmd.acc_k) ? 64'd0 - {1'b0, qmag[c]} : {1'b0, qmag[c]};
			sum65[c]  = {row_eff.f[c][63], row_eff.f[c]} + {addend[c][63], addend[c]};
			sat[c]    = sum65[c][64] != sum65[c][63];
			if (!sat[c]) begin
				row_new.f[c] = sum65[c][63:0];
			end else if (sum65[c][64]) begin
				row_new.f[c] = F_MIN;
			end else begin
				row_new.f[c] = F_MAX;
			end
		end
		row_new.err = row_eff.err | err_pair | (|sat);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_ld) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			res.body_index  <= INDEX_W'(idx_acc);
			res.force_x     <= $signed(row_eff.f[0]);
			res.force_y     <= $signed(row_eff.f[1]);
			res.force_z     <= $signed(row_eff.f[2]);
			res.apply_force <= !ra_fix_q;
			res.pair_error  <= row_eff.err;
			res.last_result <= cmd.emit_last;
		end
	end

	assign res.valid    = out_valid_q;
	assign sts.out_busy = out_valid_q & !res.ready;
	assign sts.r2_zero  = (sq_q[0] == '0) && (sq_q[1] == '0) && (sq_q[2] == '0);
endmodule

### rtl/core/gf_ctl.sv
// ----------------------------------------------------------------------------
// gf_ctl
// controller: body loading, pair sequencing and result emission
// ----------------------------------------------------------------------------
module gf_ctl #(
	parameter int MAX_BODIES = 64,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	input  gf_pkg::sts_t  sts,
	output gf_pkg::cmd_t  cmd,
	output logic [AW-1:0] idx_ld,
	output logic [AW-1:0] idx_a,
	output logic [AW-1:0] idx_b,
	output logic [AW-1:0] idx_acc
);
	import gf_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE    = 19'd1 << 0,
		S_CLEAR   = 19'd1 << 1,
		S_FETCH   = 19'd1 << 2,
		S_DIFF    = 19'd1 << 3,
		S_SQR     = 19'd1 << 4,
		S_SUM     = 19'd1 << 5,
		S_SQRT    = 19'd1 << 6,
		S_DENI    = 19'd1 << 7,
		S_DEN     = 19'd1 << 8,
		S_NUMI    = 19'd1 << 9,
		S_NUM     = 19'd1 << 10,
		S_DIVI    = 19'd1 << 11,
		S_DIV     = 19'd1 << 12,
		S_ACC_RJ  = 19'd1 << 13,
		S_ACC_WJ  = 19'd1 << 14,
		S_ACC_RK  = 19'd1 << 15,
		S_ACC_WK  = 19'd1 << 16,
		S_EMIT_RD = 19'd1 << 17,
		S_EMIT_LD = 19'd1 << 18
	} state_t;

	state_t        state_q, state_d;
	logic [5:0]    cnt_q, cnt_d;
	logic [CW-1:0] count_q, count_d, n_q, n_d, stored;
	logic [AW-1:0] j_q, j_d, k_q, k_d, i_q, i_d;
	logic          fire, room, emitting, is_last;

	assign fire     = in_valid & in_ready;
	assign room     = count_q < CW'(MAX_BODIES);
	assign stored   = count_q + CW'(room);
	assign in_ready = state_q == S_IDLE;
	assign emitting = (state_q == S_EMIT_RD) || (state_q == S_EMIT_LD);
	assign is_last  = CW'(i_q) == n_q - CW'(1);

	assign idx_ld  = count_q[AW-1:0];
	assign idx_a   = emitting ? i_q : j_q;
	assign idx_b   = k_q;
	assign idx_acc = emitting ? i_q :
		((state_q == S_ACC_RK) || (state_q == S_ACC_WK)) ? k_q : j_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q + 6'd1;
		count_d = count_q;
		n_d     = n_q;
		j_d     = j_q;
		k_d     = k_q;
		i_d     = i_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (fire) begin
					cmd.body_wr = room;
					count_d     = stored;
					if (in_last) begin
						count_d = '0;
						if (stored >= CW'(2)) begin
							n_d     = stored;
							state_d = S_CLEAR;
						end
					end
				end
			end
			S_CLEAR: begin
				cmd.acc_clear = 1'b1;
				j_d     = AW'(1);
				k_d     = '0;
				state_d = S_FETCH;
			end
			S_FETCH: state_d = S_DIFF;
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_SQR;
			end
			S_SQR: begin
				cmd.sqr = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				cnt_d   = '0;
				state_d = sts.r2_zero ? S_ACC_RJ : S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cmd.base_step = cnt_q < BASE_STEPS;
				if (cnt_q == SQRT_LAST) state_d = S_DENI;
			end
			S_DENI: begin
				cmd.den_init = 1'b1;
				cnt_d   = '0;
				state_d = S_DEN;
			end
			S_DEN: begin
				cmd.den_step = 1'b1;
				if (cnt_q == DEN_LAST) state_d = S_NUMI;
			end
			S_NUMI: begin
				cmd.num_init = 1'b1;
				cnt_d   = '0;
				state_d = S_NUM;
			end
			S_NUM: begin
				cmd.num_step = 1'b1;
				if (cnt_q == NUM_LAST) state_d = S_DIVI;
			end
			S_DIVI: begin
				cmd.div_init = 1'b1;
				cnt_d   = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) state_d = S_ACC_RJ;
			end
			S_ACC_RJ: state_d = S_ACC_WJ;
			S_ACC_WJ: begin
				cmd.acc_wr = 1'b1;
				state_d    = S_ACC_RK;
			end
			S_ACC_RK: state_d = S_ACC_WK;
			S_ACC_WK: begin
				cmd.acc_wr = 1'b1;
				cmd.acc_k  = 1'b1;
				if ((AW+1)'(k_q) + (AW+1)'(1) < (AW+1)'(j_q)) begin
					k_d     = k_q + AW'(1);
					state_d = S_FETCH;
				end else if (CW'(j_q) + CW'(1) == n_q) begin
					i_d     = '0;
					state_d = S_EMIT_RD;
				end else begin
					j_d     = j_q + AW'(1);
					k_d     = '0;
					state_d = S_FETCH;
				end
			end
			S_EMIT_RD: begin
				if (!sts.out_busy) state_d = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				cmd.emit_ld   = 1'b1;
				cmd.emit_last = is_last;
				if (is_last) begin
					state_d = S_IDLE;
				end else begin
					i_d     = i_q + AW'(1);
					state_d = S_EMIT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			count_q <= '0;
			n_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			i_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			count_q <= count_d;
			n_q     <= n_d;
			j_q     <= j_d;
			k_q     <= k_d;
			i_q     <= i_d;
		end
	end
endmodule

### rtl/core/all_pairs_gravity_forces_top.sv
// ----------------------------------------------------------------------------
// all_pairs_gravity_forces_top
// direct-sum newtonian gravity over a loaded set of up to MAX_BODIES bodies
// ----------------------------------------------------------------------------
// Bodies are loaded one beat per cycle while idle (mass Q16.16, position
// Q16.16, fixed flag); bodies beyond MAX_BODIES are dropped. The beat carrying
// last_body starts a run: every pair (j,k) with k<j adds G*mj*mk*d/|d|^3 to
// body j and subtracts it from body k, forces are Q32.32 and saturate. One
// result beat per body then follows in load order, the final one flagged
// last_result. Fewer than two bodies gives no results. Each pair runs on the
// shared pair unit (50-step square root, 50-step denominator product, 33-step
// numerator products and 63-step divisions on three axis lanes); a coincident
// pair skips the root, products and divisions. No body is accepted during a run.
// ----------------------------------------------------------------------------
module all_pairs_gravity_forces_top #(
	parameter int MAX_BODIES = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [gf_pkg::ADDR_W-1:0] paddr,
	input  logic [gf_pkg::DATA_W-1:0] pwdata,
	output logic [gf_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	// body beats in, force beats out
	gf_in_if.sink                     body_in,
	gf_out_if.source                  force_out
);
	import gf_pkg::*;

	localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
	localparam int CW = $clog2(MAX_BODIES + 1);

	logic [G_W-1:0] big_g_q;
	cmd_t           cmd;
	sts_t           sts;
	logic [AW-1:0]  idx_ld, idx_a, idx_b, idx_acc;
	logic           cfg_wr;

	// register write on the access phase, no wait states
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_g_q <= BIG_G_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2:2])
				REG_BIG_G: big_g_q <= pwdata;
				default:   big_g_q <= big_g_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2:2])
			REG_BIG_G: prdata = big_g_q;
			default:   prdata = '0;
		endcase
	end

	// sequencer
	gf_ctl #(
		.MAX_BODIES (MAX_BODIES),
		.AW         (AW),
		.CW         (CW)
	) u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (body_in.valid),
		.in_last  (body_in.last_body),
		.in_ready (body_in.ready),
		.sts      (sts),
		.cmd      (cmd),
		.idx_ld   (idx_ld),
		.idx_a    (idx_a),
		.idx_b    (idx_b),
		.idx_acc  (idx_acc)
	);

	// body store, pair unit, accumulators and result register
	gf_dp #(
		.MAX_BODIES (MAX_BODIES),
		.AW         (AW)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.idx_ld   (idx_ld),
		.idx_a    (idx_a),
		.idx_b    (idx_b),
		.idx_acc  (idx_acc),
		.big_g    (big_g_q),
		.in_mass  (body_in.mass),
		.in_pos_x (body_in.pos_x),
		.in_pos_y (body_in.pos_y),
		.in_pos_z (body_in.pos_z),
		.in_fixed (body_in.is_fixed),
		.res      (force_out)
	);
endmodule
